// File: rtl/core/dssp_pkg.sv
// Shared definitions for the dual stepper shortest-path indexer.
// Holds field widths, command codes and the shared add/subtract unit opcodes.
// No dependencies.
package dssp_pkg;

  // Default number of steps per disk turn
  localparam int POSITIONS_DEF = 48;

  // Width of the position and target fields on the ports
  localparam int POS_W = 6;

  // Command codes
  localparam logic CMD_SET  = 1'b0;
  localparam logic CMD_MOVE = 1'b1;

  // Operations of the shared add/subtract unit
  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

endpackage

// File: rtl/core/dssp_alu.sv
// Shared add/subtract unit of the dual stepper shortest-path indexer.
// Depends on dssp_pkg for the opcode type.
// The result MSB serves as the borrow flag when operands are zero-extended.
module dssp_alu #(
  parameter int W = 8
) (
  input  dssp_pkg::alu_op_t op,
  input  logic [W-1:0]      a,
  input  logic [W-1:0]      b,
  output logic [W-1:0]      r
);

  always_comb begin
    unique case (op)
      dssp_pkg::ALU_ADD: r = a + b;
      dssp_pkg::ALU_SUB: r = a - b;
      default:           r = '0;
    endcase
  end

endmodule

// File: rtl/core/dual_stepper_shortest_path_indexer.sv
// Dual stepper shortest-path indexer, top level.
// Depends on dssp_pkg and instantiates dssp_alu, the shared add/subtract unit.
//
// Two stepper-driven disks with POSITIONS steps per turn are tracked modulo
// POSITIONS. A set command (command = 0) loads both positions and returns one
// word with no pulses and last = 1. A move command (command = 1) picks, per
// disk, the shortest way to its target (forward wins a tie), latches the
// directions, then returns one word per step cycle while the output side
// does not stall, with a pulse on every axis that still has steps left, and
// ends with a word with no pulses and last = 1. Targets of POSITIONS or more
// are first reduced modulo POSITIONS. All setup arithmetic runs through one
// shared add/subtract unit under a small sequencer, and the block holds
// in_stall high until the final word of a command has been loaded into the
// output register. For each disk in turn the target is reduced by
// subtracting POSITIONS while it is not below it (for POSITIONS = 48 a 6-bit
// target needs at most one subtraction); a move then works out each disk's
// distance in turn (difference, wrap only when the difference went negative,
// backward distance, compare) and returns as many step words as the larger
// of the two distances, at most POSITIONS/2, then the final word. The block
// returns to idle before it takes the next command.
module dual_stepper_shortest_path_indexer #(
  parameter int POSITIONS = dssp_pkg::POSITIONS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  // input channel
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       command,
  input  logic [dssp_pkg::POS_W-1:0] target_a,
  input  logic [dssp_pkg::POS_W-1:0] target_b,
  // output channel
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       step_a,
  output logic                       step_b,
  output logic                       dir_a,
  output logic                       dir_b,
  output logic [dssp_pkg::POS_W-1:0] position_a,
  output logic [dssp_pkg::POS_W-1:0] position_b,
  output logic                       last
);

  // PW holds a position; TW also holds a raw target field
  localparam int PW = $clog2(POSITIONS);
  localparam int TW = (PW > dssp_pkg::POS_W) ? PW : dssp_pkg::POS_W;
  // One extra bit so the unit's MSB is the borrow
  localparam int UW = TW + 1;
  // Step count never exceeds POSITIONS/2
  localparam int LW = $clog2(POSITIONS / 2 + 1);

  localparam logic [UW-1:0] P_U    = UW'(POSITIONS);
  localparam logic [TW-1:0] P_LAST = TW'(POSITIONS - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RED,   // reduce target of selected axis modulo POSITIONS
    ST_DIF,   // forward difference target - position
    ST_WRAP,  // add POSITIONS when the difference went negative
    ST_BWD,   // backward distance POSITIONS - forward
    ST_CMP,   // pick the shorter way, latch direction and step count
    ST_STEP   // one word per cycle while the output is free, final word last
  } state_t;

  state_t          state;
  logic            sel;      // axis under work: 0 = a, 1 = b
  logic            cmd;
  logic [TW-1:0]   tgt_a;
  logic [TW-1:0]   tgt_b;
  logic [UW-1:0]   fwd_dist;
  logic [UW-1:0]   bwd;
  logic [TW-1:0]   pos_a;
  logic [TW-1:0]   pos_b;
  logic [LW-1:0]   left_a;
  logic [LW-1:0]   left_b;
  logic            dir_reg_a;
  logic            dir_reg_b;

  dssp_pkg::alu_op_t alu_op;
  logic [UW-1:0]     alu_a;
  logic [UW-1:0]     alu_b;
  logic [UW-1:0]     alu_r;
  logic              borrow;

  logic [TW-1:0]   tgt_sel;
  logic [TW-1:0]   pos_sel;
  logic [TW-1:0]   pos_a_next;
  logic [TW-1:0]   pos_b_next;
  logic            out_free;
  logic            load_word;
  logic            steps_done;

  assign in_stall   = (state != ST_IDLE);
  assign out_free   = !out_valid || !out_stall;
  assign load_word  = (state == ST_STEP) && out_free;
  assign steps_done = (left_a == '0) && (left_b == '0);
  assign borrow     = alu_r[UW-1];

  assign tgt_sel = sel ? tgt_b : tgt_a;
  assign pos_sel = sel ? pos_b : pos_a;

  // Operand select for the shared unit
  always_comb begin
    alu_op = dssp_pkg::ALU_SUB;
    alu_a  = '0;
    alu_b  = '0;
    unique case (state)
      ST_RED: begin
        alu_a = {1'b0, tgt_sel};
        alu_b = P_U;
      end
      ST_DIF: begin
        alu_a = {1'b0, tgt_sel};
        alu_b = {1'b0, pos_sel};
      end
      ST_WRAP: begin
        alu_op = dssp_pkg::ALU_ADD;
        alu_a  = fwd_dist;
        alu_b  = P_U;
      end
      ST_BWD: begin
        alu_a = P_U;
        alu_b = fwd_dist;
      end
      ST_CMP: begin
        alu_a = bwd;
        alu_b = fwd_dist;
      end
      default: begin
        alu_op = dssp_pkg::ALU_SUB;
      end
    endcase
  end

  dssp_alu #(
    .W(UW)
  ) u_alu (
    .op(alu_op),
    .a (alu_a),
    .b (alu_b),
    .r (alu_r)
  );

  // Position after this cycle's pulse: wrap at both ends of the turn
  always_comb begin
    pos_a_next = pos_a;
    pos_b_next = pos_b;
    if (left_a != '0) begin
      if (dir_reg_a) begin
        pos_a_next = (pos_a == P_LAST) ? '0 : pos_a + TW'(1);
      end else begin
        pos_a_next = (pos_a == '0) ? P_LAST : pos_a - TW'(1);
      end
    end
    if (left_b != '0) begin
      if (dir_reg_b) begin
        pos_b_next = (pos_b == P_LAST) ? '0 : pos_b + TW'(1);
      end else begin
        pos_b_next = (pos_b == '0) ? P_LAST : pos_b - TW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      sel       <= 1'b0;
      out_valid <= 1'b0;
      pos_a     <= '0;
      pos_b     <= '0;
      left_a    <= '0;
      left_b    <= '0;
      dir_reg_a <= 1'b1;
      dir_reg_b <= 1'b1;
    end else begin
      // Load a new word, or drop the held one once the output side takes it
      if (load_word) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            cmd   <= command;
            tgt_a <= TW'(target_a);
            tgt_b <= TW'(target_b);
            sel   <= 1'b0;
            state <= ST_RED;
          end
        end

        ST_RED: begin
          if (!borrow) begin
            // still at or above POSITIONS: subtract again
            if (sel) begin
              tgt_b <= alu_r[TW-1:0];
            end else begin
              tgt_a <= alu_r[TW-1:0];
            end
          end else if (!sel) begin
            sel <= 1'b1;
          end else begin
            sel <= 1'b0;
            if (cmd == dssp_pkg::CMD_SET) begin
              pos_a  <= tgt_a;
              pos_b  <= tgt_b;
              left_a <= '0;
              left_b <= '0;
              state  <= ST_STEP;
            end else begin
              state <= ST_DIF;
            end
          end
        end

        ST_DIF: begin
          fwd_dist <= alu_r;
          state    <= borrow ? ST_WRAP : ST_BWD;
        end

        ST_WRAP: begin
          fwd_dist <= alu_r;
          state    <= ST_BWD;
        end

        ST_BWD: begin
          bwd   <= alu_r;
          state <= ST_CMP;
        end

        ST_CMP: begin
          // Zero distance keeps the direction; forward wins a tie
          if (sel) begin
            if (fwd_dist == '0) begin
              left_b <= '0;
            end else if (!borrow) begin
              dir_reg_b <= 1'b1;
              left_b    <= fwd_dist[LW-1:0];
            end else begin
              dir_reg_b <= 1'b0;
              left_b    <= bwd[LW-1:0];
            end
            sel   <= 1'b0;
            state <= ST_STEP;
          end else begin
            if (fwd_dist == '0) begin
              left_a <= '0;
            end else if (!borrow) begin
              dir_reg_a <= 1'b1;
              left_a    <= fwd_dist[LW-1:0];
            end else begin
              dir_reg_a <= 1'b0;
              left_a    <= bwd[LW-1:0];
            end
            sel   <= 1'b1;
            state <= ST_DIF;
          end
        end

        ST_STEP: begin
          // Advance one word whenever the output register is free
          if (out_free) begin
            step_a     <= (left_a != '0);
            step_b     <= (left_b != '0);
            dir_a      <= dir_reg_a;
            dir_b      <= dir_reg_b;
            position_a <= pos_a_next[dssp_pkg::POS_W-1:0];
            position_b <= pos_b_next[dssp_pkg::POS_W-1:0];
            last       <= steps_done;
            pos_a      <= pos_a_next;
            pos_b      <= pos_b_next;
            if (left_a != '0) begin
              left_a <= left_a - LW'(1);
            end
            if (left_b != '0) begin
              left_b <= left_b - LW'(1);
            end
            if (steps_done) begin
              state <= ST_IDLE;
            end
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // The final word of a command never carries a pulse
  a_last_no_pulse: assert property (@(posedge clk) disable iff (rst)
    out_valid && last |-> !step_a && !step_b)
    else $error("final word carries a step pulse");

  // Between commands no steps are pending
  a_idle_no_steps: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> left_a == '0 && left_b == '0)
    else $error("steps pending while idle");

  // Tracked positions stay within one turn
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    {1'b0, pos_a} < P_U && {1'b0, pos_b} < P_U)
    else $error("tracked position out of range");

  // The shortest way is never more than half a turn
  a_left_range: assert property (@(posedge clk) disable iff (rst)
    left_a <= LW'(POSITIONS / 2) && left_b <= LW'(POSITIONS / 2))
    else $error("step count exceeds half a turn");

  // An accepted command leaves idle on the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> state != ST_IDLE)
    else $error("accepted command did not start");

endmodule
